// ===== design/otrb_pkg.sv =====
// shared types and constants for the overwriting trace ring
`default_nettype none

package otrb_pkg;

    localparam int RING_ENTRIES_DEF = 32;

    localparam int PAGE_W   = 40;
    localparam int VCPU_W   = 8;
    localparam int STAMP_W  = 64;
    localparam int WINDOW_W = 32;
    localparam int LIMIT_W  = 16;
    localparam int CNT_W    = 32;
    localparam int ADDR_W   = 52;
    localparam int DCOUNT_W = 6;
    localparam int ADDR_LSB = 12;

    localparam int S_TDATA_W = 160;
    localparam int M_TDATA_W = 168;

    typedef enum logic {
        OP_LOG   = 1'b0,
        OP_DRAIN = 1'b1
    } t_op;

    typedef enum logic {
        KIND_ENTRY   = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEND,
        ST_SUM
    } t_state;

    typedef struct packed {
        logic [VCPU_W-1:0]   vcpu;
        logic [WINDOW_W-1:0] window;
        logic [STAMP_W-1:0]  stamp;
        logic [PAGE_W-1:0]   page;
    } t_entry;

    typedef struct packed {
        logic log_wr;
        logic drain_start;
        logic entry_adv;
        logic show_sum;
    } t_dp_cmd;

    typedef struct packed {
        logic remain_zero;
        logic remain_one;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== design/overwrite_trace_ring_buffer_core.sv =====
// Overwriting trace ring: a log word (tuser 0) stores its event in the
// slot picked by the free-running write counter, producing no output. A drain word (tuser 1)
// holds the input off while it runs: it starts the drain, makes the registered read of
// the entry memory, then sends one entry per cycle while the sink is ready, oldest first, and a
// summary word marked tlast.
// The single registered read port of the entry memory sets that one-entry-per-cycle pace.
// Entries never written read back as whatever the memory holds; no clearing pass is run.
`default_nettype none

module overwrite_trace_ring_buffer_core #(
    parameter int RING_ENTRIES = otrb_pkg::RING_ENTRIES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // page_number[39:0], vcpu[47:40], stamp[111:48], window_id[143:112], drain_limit[159:144]
    input  wire logic [otrb_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // op[0]
    input  wire logic                           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // fault_address[51:0], entry_stamp[115:52], entry_window[147:116], entry_vcpu[155:148],
    // drained_count[161:156], zero fill[167:162]
    output logic [otrb_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // kind[0]
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast
);
    import otrb_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    otrb_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_op          (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_cmd         (cmd),
        .i_sts         (sts)
    );

    otrb_dp #(
        .RING_ENTRIES (RING_ENTRIES)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tdata (s_axis_tdata),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .o_m_tdata (m_axis_tdata),
        .o_m_tuser (m_axis_tuser),
        .o_m_tlast (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== design/otrb_ctrl.sv =====
// controller state machine for the trace ring: accepts items and sequences drains
`default_nettype none

module otrb_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic             i_op,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output otrb_pkg::t_dp_cmd     o_cmd,
    input  wire otrb_pkg::t_dp_sts i_sts
);
    import otrb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        o_cmd         = '0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    if (t_op'(i_op) == OP_DRAIN) begin
                        o_cmd.drain_start = 1'b1;
                        n_state           = ST_READ;
                    end else begin
                        o_cmd.log_wr = 1'b1;
                    end
                end
            end
            // memory read of the oldest entry is in flight
            ST_READ: begin
                n_state = i_sts.remain_zero ? ST_SUM : ST_SEND;
            end
            ST_SEND: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    o_cmd.entry_adv = 1'b1;
                    if (i_sts.remain_one) begin
                        n_state = ST_SUM;
                    end
                end
            end
            ST_SUM: begin
                m_axis_tvalid  = 1'b1;
                o_cmd.show_sum = 1'b1;
                if (m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/otrb_dp.sv =====
// datapath for the trace ring: counters, slot tracking, entry memory and output words
`default_nettype none

module otrb_dp #(
    parameter int RING_ENTRIES = otrb_pkg::RING_ENTRIES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [otrb_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  wire otrb_pkg::t_dp_cmd               i_cmd,
    output otrb_pkg::t_dp_sts                    o_sts,
    output logic [otrb_pkg::M_TDATA_W-1:0]       o_m_tdata,
    output logic                                 o_m_tuser,
    output logic                                 o_m_tlast
);
    import otrb_pkg::*;

    localparam int AW = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1;
    localparam int CW = $clog2(RING_ENTRIES + 1);
    // slot offset that the counter wrap at 2^32 introduces
    localparam logic [63:0] WRAP_REM = (64'd1 << 32) % RING_ENTRIES;

    function automatic logic [AW-1:0] f_next_slot(input logic [CNT_W-1:0] cnt,
                                                  input logic [AW-1:0] slot);
        logic [AW-1:0] res;
        if (cnt == {CNT_W{1'b1}}) begin
            res = '0;
        end else if (slot == AW'(RING_ENTRIES - 1)) begin
            res = '0;
        end else begin
            res = slot + AW'(1);
        end
        return res;
    endfunction

    t_entry mem [RING_ENTRIES];
    t_entry r_rd_word;

    logic [CNT_W-1:0] r_wr_cnt;
    logic [AW-1:0]    r_wr_slot;
    logic [CNT_W-1:0] r_rd_cnt;
    logic [AW-1:0]    r_rd_slot;
    logic [CW-1:0]    r_remain;
    logic [CW-1:0]    r_count;

    t_entry           in_entry;
    logic [LIMIT_W-1:0] in_limit;
    logic [CNT_W-1:0] pend;
    logic             lapped;
    logic [AW:0]      jump_sum;
    logic [AW-1:0]    jump_slot;
    logic [CNT_W-1:0] tail_cnt;
    logic [AW-1:0]    tail_slot;
    logic [CW-1:0]    pend_n;
    logic [CW-1:0]    limit_n;
    logic [AW-1:0]    rd_addr;

    assign in_entry.page   = i_s_tdata[PAGE_W-1:0];
    assign in_entry.vcpu   = i_s_tdata[PAGE_W +: VCPU_W];
    assign in_entry.stamp  = i_s_tdata[PAGE_W+VCPU_W +: STAMP_W];
    assign in_entry.window = i_s_tdata[PAGE_W+VCPU_W+STAMP_W +: WINDOW_W];
    assign in_limit        = i_s_tdata[PAGE_W+VCPU_W+STAMP_W+WINDOW_W +: LIMIT_W];

    always_comb begin
        pend   = r_wr_cnt - r_rd_cnt;
        lapped = pend > CNT_W'(RING_ENTRIES);
        // slot of write_count minus ring size, borrowing across the 2^32 wrap
        jump_sum = {1'b0, r_wr_slot} + (AW+1)'(WRAP_REM);
        if (jump_sum >= (AW+1)'(RING_ENTRIES)) begin
            jump_sum = jump_sum - (AW+1)'(RING_ENTRIES);
        end
        if (r_wr_cnt >= CNT_W'(RING_ENTRIES)) begin
            jump_slot = r_wr_slot;
        end else begin
            jump_slot = jump_sum[AW-1:0];
        end
        if (lapped) begin
            tail_cnt  = r_wr_cnt - CNT_W'(RING_ENTRIES);
            tail_slot = jump_slot;
            pend_n    = CW'(RING_ENTRIES);
        end else begin
            tail_cnt  = r_rd_cnt;
            tail_slot = r_rd_slot;
            pend_n    = pend[CW-1:0];
        end
        if (in_limit > LIMIT_W'(RING_ENTRIES)) begin
            limit_n = CW'(RING_ENTRIES);
        end else begin
            limit_n = in_limit[CW-1:0];
        end
    end

    // prefetch the following slot on the handshake so entries stream each cycle
    assign rd_addr = i_cmd.entry_adv ? f_next_slot(r_rd_cnt, r_rd_slot) : r_rd_slot;

    always_ff @(posedge i_clk) begin
        if (i_cmd.log_wr) begin
            mem[r_wr_slot] <= in_entry;
        end
        r_rd_word <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_cnt  <= '0;
            r_wr_slot <= '0;
            r_rd_cnt  <= '0;
            r_rd_slot <= '0;
            r_remain  <= '0;
            r_count   <= '0;
        end else begin
            if (i_cmd.log_wr) begin
                r_wr_cnt  <= r_wr_cnt + CNT_W'(1);
                r_wr_slot <= f_next_slot(r_wr_cnt, r_wr_slot);
            end
            if (i_cmd.drain_start) begin
                r_rd_cnt  <= tail_cnt;
                r_rd_slot <= tail_slot;
                r_remain  <= (pend_n < limit_n) ? pend_n : limit_n;
                r_count   <= '0;
            end else if (i_cmd.entry_adv) begin
                r_rd_cnt  <= r_rd_cnt + CNT_W'(1);
                r_rd_slot <= rd_addr;
                r_remain  <= r_remain - CW'(1);
                r_count   <= r_count + CW'(1);
            end
        end
    end

    assign o_sts.remain_zero = (r_remain == '0);
    assign o_sts.remain_one  = (r_remain == CW'(1));

    always_comb begin
        o_m_tdata = '0;
        if (i_cmd.show_sum) begin
            o_m_tdata[ADDR_W+STAMP_W+WINDOW_W+VCPU_W +: DCOUNT_W] = DCOUNT_W'(r_count);
            o_m_tuser = KIND_SUMMARY;
            o_m_tlast = 1'b1;
        end else begin
            o_m_tdata[ADDR_W-1:0] = {r_rd_word.page, {ADDR_LSB{1'b0}}};
            o_m_tdata[ADDR_W +: STAMP_W] = r_rd_word.stamp;
            o_m_tdata[ADDR_W+STAMP_W +: WINDOW_W] = r_rd_word.window;
            o_m_tdata[ADDR_W+STAMP_W+WINDOW_W +: VCPU_W] = r_rd_word.vcpu;
            o_m_tuser = KIND_ENTRY;
            o_m_tlast = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== design/otrb_checker.sv =====
// port-level checks for the trace ring, bound to the top level
`default_nettype none

module otrb_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic s_axis_tvalid,
    input wire logic s_axis_tready,
    input wire logic s_axis_tuser,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready,
    input wire logic m_axis_tuser,
    input wire logic m_axis_tlast
);
    import otrb_pkg::*;

    // a stalled output word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word withdrawn while stalled");

    // no new word is taken while a drain is emitting
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready during drain output");

    // only the summary carries tlast
    a_last_is_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser))
        else $error("tlast and summary kind disagree");

    // the summary closes the drain
    a_sum_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
        else $error("output continued after summary");

    // a drain word blocks the input on the next cycle
    a_drain_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_DRAIN) |=> !s_axis_tready)
        else $error("input ready right after drain word");

endmodule

bind overwrite_trace_ring_buffer_core otrb_checker u_otrb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
